### rtl/core/lfa_pkg.sv
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared constants, register codes and the per-cell rule function for the
// Life 8x8 leaf advance block.
// ----------------------------------------------------------------------------
package lfa_pkg;

    localparam int QUAD_W    = 16;
    localparam int QUAD_N    = 4;
    localparam int GRID_N    = 8;
    localparam int RULE_W    = 9;
    localparam int NBR_W     = 8;
    localparam int CNT_W     = 4;
    localparam int RULE_REGS = 2;
    localparam int CFG_IDX_W = $clog2(RULE_REGS);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = CFG_IDX_W'(1);

    // B3/S23
    localparam logic [RULE_W-1:0] BIRTH_RESET   = RULE_W'(8);
    localparam logic [RULE_W-1:0] SURVIVE_RESET = RULE_W'(12);

    // next state of one cell from its own state and its eight neighbors
    function automatic logic cell_next(
        input logic              alive,
        input logic [NBR_W-1:0]  nbrs,
        input logic [RULE_W-1:0] birth,
        input logic [RULE_W-1:0] survive
    );
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int k = 0; k < NBR_W; k++) begin
            cnt = cnt + CNT_W'(nbrs[k]);
        end
        return alive ? survive[cnt] : birth[cnt];
    endfunction

endpackage

### rtl/core/life_8x8_leaf_advance.sv
// ----------------------------------------------------------------------------
// life_8x8_leaf_advance
// Advances an 8x8 Life block by one or two generations and returns the
// centered 4x4 block, under a configurable birth/survive rule.
// ----------------------------------------------------------------------------
// Throughput is one block per clock: a three-stage pipeline (input grid
// register, first-generation register, result register) accepts a new beat
// every cycle while the output side takes results, and a result is offered
// once its beat has passed through all three registers. The rule masks live
// in a two-entry RAM with registered read; both entries are read every cycle,
// and a per-entry valid bit (cleared by reset) makes an unwritten entry read
// as the B3/S23 default. A rule write applies to every beat accepted from the
// cycle after the write onward.
// ----------------------------------------------------------------------------
module life_8x8_leaf_advance (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [lfa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lfa_pkg::RULE_W-1:0]       i_cfg_wdata,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lfa_pkg::QUAD_W-1:0]       i_quad_nw,
    input  logic [lfa_pkg::QUAD_W-1:0]       i_quad_ne,
    input  logic [lfa_pkg::QUAD_W-1:0]       i_quad_sw,
    input  logic [lfa_pkg::QUAD_W-1:0]       i_quad_se,
    input  logic                             i_two_gens,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lfa_pkg::QUAD_W-1:0]       o_center_next
);

    localparam int GRID_BITS = lfa_pkg::GRID_N * lfa_pkg::GRID_N;
    localparam int G1_N      = lfa_pkg::GRID_N - 2;
    localparam int G1_BITS   = G1_N * G1_N;
    localparam int QN        = lfa_pkg::QUAD_N;

    // ------------------------------------------------------------------
    // Rule storage: entry REG_BIRTH and entry REG_SURVIVE, read every cycle
    // ------------------------------------------------------------------
    logic [lfa_pkg::RULE_W-1:0]    w_birth_raw;
    logic [lfa_pkg::RULE_W-1:0]    w_survive_raw;
    logic [lfa_pkg::RULE_W-1:0]    w_birth;
    logic [lfa_pkg::RULE_W-1:0]    w_survive;
    logic [lfa_pkg::RULE_REGS-1:0] r_rule_vld;
    logic [lfa_pkg::RULE_REGS-1:0] r_rule_vld_d;
    logic [lfa_pkg::RULE_REGS-1:0] n_rule_vld;

    lfa_ram #(
        .WIDTH (lfa_pkg::RULE_W),
        .DEPTH (lfa_pkg::RULE_REGS)
    ) u_rule_ram (
        .i_clk     (i_clk),
        .i_we      (i_cfg_we),
        .i_waddr   (i_cfg_index),
        .i_wdata   (i_cfg_wdata),
        .i_raddr_a (lfa_pkg::REG_BIRTH),
        .i_raddr_b (lfa_pkg::REG_SURVIVE),
        .o_rdata_a (w_birth_raw),
        .o_rdata_b (w_survive_raw)
    );

    // Mark an entry written; the delayed copy lines up with the read data.
    always_comb begin
        n_rule_vld = r_rule_vld;
        if (i_cfg_we) begin
            n_rule_vld[i_cfg_index] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_vld   <= '0;
            r_rule_vld_d <= '0;
        end else begin
            r_rule_vld   <= n_rule_vld;
            r_rule_vld_d <= r_rule_vld;
        end
    end

    assign w_birth   = r_rule_vld_d[lfa_pkg::REG_BIRTH]   ? w_birth_raw
                                                           : lfa_pkg::BIRTH_RESET;
    assign w_survive = r_rule_vld_d[lfa_pkg::REG_SURVIVE] ? w_survive_raw
                                                           : lfa_pkg::SURVIVE_RESET;

    // ------------------------------------------------------------------
    // Pipeline control: each stage advances when the next one is free
    // ------------------------------------------------------------------
    logic r_s1_vld;
    logic r_s2_vld;
    logic r_out_vld;
    logic w_out_free;
    logic w_s2_free;
    logic w_s1_free;
    logic w_in_acc;

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_s2_free  = !r_s2_vld  || w_out_free;
    assign w_s1_free  = !r_s1_vld  || w_s2_free;
    assign o_in_ready = w_s1_free;
    assign w_in_acc   = i_in_valid && w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_vld <= i_in_valid;
            end
            if (w_s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_out_free) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    assign o_out_valid = r_out_vld;

    // ------------------------------------------------------------------
    // Stage 1: assemble the 8x8 grid, row-major, top-left at index 0
    // ------------------------------------------------------------------
    logic [GRID_BITS-1:0] n_grid;
    logic [GRID_BITS-1:0] r_grid;
    logic                 r_s1_two;

    always_comb begin
        n_grid = '0;
        for (int r = 0; r < QN; r++) begin
            for (int c = 0; c < QN; c++) begin
                n_grid[r*lfa_pkg::GRID_N + c]             = i_quad_nw[QN*QN-1 - (r*QN + c)];
                n_grid[r*lfa_pkg::GRID_N + c + QN]        = i_quad_ne[QN*QN-1 - (r*QN + c)];
                n_grid[(r+QN)*lfa_pkg::GRID_N + c]        = i_quad_sw[QN*QN-1 - (r*QN + c)];
                n_grid[(r+QN)*lfa_pkg::GRID_N + c + QN]   = i_quad_se[QN*QN-1 - (r*QN + c)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_grid   <= n_grid;
            r_s1_two <= i_two_gens;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first generation over rows and columns 1..6
    // ------------------------------------------------------------------
    logic [G1_BITS-1:0] n_g1;
    logic [G1_BITS-1:0] r_g1;
    logic               r_s2_two;

    lfa_step #(
        .OUT_N (G1_N)
    ) u_gen1 (
        .i_grid    (r_grid),
        .i_birth   (w_birth),
        .i_survive (w_survive),
        .o_next    (n_g1)
    );

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && w_s2_free) begin
            r_g1     <= n_g1;
            r_s2_two <= r_s1_two;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: second generation over the center, or take gen-1 center
    // ------------------------------------------------------------------
    logic [QN*QN-1:0]          w_g2;
    logic [QN*QN-1:0]          w_pick;
    logic [lfa_pkg::QUAD_W-1:0] n_center;
    logic [lfa_pkg::QUAD_W-1:0] r_center;

    lfa_step #(
        .OUT_N (QN)
    ) u_gen2 (
        .i_grid    (r_g1),
        .i_birth   (w_birth),
        .i_survive (w_survive),
        .o_next    (w_g2)
    );

    always_comb begin
        for (int r = 0; r < QN; r++) begin
            for (int c = 0; c < QN; c++) begin
                w_pick[r*QN + c] = r_s2_two ? w_g2[r*QN + c] : r_g1[(r+1)*G1_N + c + 1];
            end
        end
        // flip to the output layout: top-left in the top bit
        for (int k = 0; k < QN*QN; k++) begin
            n_center[lfa_pkg::QUAD_W-1 - k] = w_pick[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && w_out_free) begin
            r_center <= n_center;
        end
    end

    assign o_center_next = r_center;

`ifndef SYNTHESIS
    // an accepted beat always lands in stage 1
    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_vld)
        else $error("accepted beat did not reach stage 1");

    // a new result only comes from a valid stage 2
    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_vld || i_out_ready) && !r_s2_vld |=> !r_out_vld)
        else $error("result shown without a stage 2 beat");

    // a blocked stage 2 holds its generation
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && !w_out_free |=> r_s2_vld && $stable(r_g1) && $stable(r_s2_two))
        else $error("stage 2 lost its beat under backpressure");

    // a birth write shows up on the rule through the registered RAM read and the delayed valid bit
    a_birth_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == lfa_pkg::REG_BIRTH)
        ##1 !(i_cfg_we && i_cfg_index == lfa_pkg::REG_BIRTH)
        |=> w_birth == $past(i_cfg_wdata, 2))
        else $error("birth mask write not applied");

    // a survive write shows up on the rule through the registered RAM read and the delayed valid bit
    a_survive_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == lfa_pkg::REG_SURVIVE)
        ##1 !(i_cfg_we && i_cfg_index == lfa_pkg::REG_SURVIVE)
        |=> w_survive == $past(i_cfg_wdata, 2))
        else $error("survive mask write not applied");
`endif

endmodule

### rtl/core/lfa_ram.sv
// ----------------------------------------------------------------------------
// lfa_ram
// Generic RAM: one write port, two read ports, registered read data
// (read-first on an address collision).
// ----------------------------------------------------------------------------
module lfa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/core/lfa_step.sv
// ----------------------------------------------------------------------------
// lfa_step
// One generation over a square window: produces the inner OUT_N x OUT_N
// cells from an (OUT_N+2) x (OUT_N+2) row-major grid, index r*side+c.
// ----------------------------------------------------------------------------
module lfa_step #(
    parameter int OUT_N = 6
) (
    input  logic [(OUT_N+2)*(OUT_N+2)-1:0] i_grid,
    input  logic [lfa_pkg::RULE_W-1:0]     i_birth,
    input  logic [lfa_pkg::RULE_W-1:0]     i_survive,
    output logic [OUT_N*OUT_N-1:0]         o_next
);

    localparam int SIDE = OUT_N + 2;

    for (genvar r = 0; r < OUT_N; r++) begin : g_row
        for (genvar c = 0; c < OUT_N; c++) begin : g_col
            logic [lfa_pkg::NBR_W-1:0] w_nbrs;
            assign w_nbrs = {
                i_grid[r*SIDE + c],     i_grid[r*SIDE + c + 1],     i_grid[r*SIDE + c + 2],
                i_grid[(r+1)*SIDE + c],                             i_grid[(r+1)*SIDE + c + 2],
                i_grid[(r+2)*SIDE + c], i_grid[(r+2)*SIDE + c + 1], i_grid[(r+2)*SIDE + c + 2]
            };
            assign o_next[r*OUT_N + c] = lfa_pkg::cell_next(
                i_grid[(r+1)*SIDE + c + 1], w_nbrs, i_birth, i_survive);
        end
    end

endmodule
